>>> rtl/core/lsk_pkg.sv
// ----------------------------------------------------------------------------
// lsk_pkg
// Shared types and constants for the longest k-distinct substring block.
// ----------------------------------------------------------------------------
package lsk_pkg;

  // Alphabet and position range
  localparam int unsigned AlphabetSize    = 26;
  localparam int unsigned MaxStringLength = 65536;
  localparam int unsigned IdxW            = $clog2(AlphabetSize);
  localparam int unsigned PosW            = $clog2(MaxStringLength);
  localparam int unsigned LenW            = PosW + 1;
  localparam int unsigned CntW            = $clog2(AlphabetSize + 1);

  // Field widths fixed by the interface
  localparam int unsigned LetterW = 5;
  localparam int unsigned KW      = 5;

  localparam logic [KW-1:0]      KReset  = KW'(3);
  localparam logic [IdxW-1:0]    LastIdx = IdxW'(AlphabetSize - 1);
  localparam logic [PosW-1:0]    LastPos = PosW'(MaxStringLength - 1);

  // Input item
  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               end_of_string;
  } lsk_in_t;

  // Result item
  typedef struct packed {
    logic [LenW-1:0] best_length;
    logic [PosW-1:0] best_start;
    logic [PosW-1:0] best_end;
    logic            is_final;
    logic            too_long;
  } lsk_out_t;

  // Sequencer to scan unit
  typedef struct packed {
    logic            start;
    logic            step;
    logic [IdxW-1:0] idx;
    logic            entry_valid;
    logic [PosW-1:0] entry_pos;
  } lsk_scan_req_t;

  // Scan unit result
  typedef struct packed {
    logic            found;
    logic [PosW-1:0] oldest;
    logic [IdxW-1:0] victim;
  } lsk_scan_res_t;

endpackage

>>> rtl/core/lsk_scan.sv
// ----------------------------------------------------------------------------
// lsk_scan
// Oldest-entry tracker: one comparator, fed one letter entry per cycle.
// ----------------------------------------------------------------------------
module lsk_scan
  import lsk_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lsk_scan_req_t req_i,
  output lsk_scan_res_t res_o
);

  logic            found_q, found_d;
  logic [PosW-1:0] oldest_q, oldest_d;
  logic [IdxW-1:0] victim_q, victim_d;
  logic            take;

  // Strictly older wins, so the lowest code wins ties
  assign take = req_i.entry_valid && (!found_q || (req_i.entry_pos < oldest_q));

  always_comb begin
    found_d  = found_q;
    oldest_d = oldest_q;
    victim_d = victim_q;
    if (req_i.start) begin
      found_d = 1'b0;
    end else if (req_i.step && take) begin
      found_d  = 1'b1;
      oldest_d = req_i.entry_pos;
      victim_d = req_i.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oldest_q <= oldest_d;
    victim_q <= victim_d;
  end

  assign res_o.found  = found_q;
  assign res_o.oldest = oldest_q;
  assign res_o.victim = victim_q;

endmodule

>>> rtl/core/longest_substring_k_distinct.sv
// ----------------------------------------------------------------------------
// longest_substring_k_distinct
// Sliding window over a letter stream holding at most k distinct letters (k = 0 acts as 1);
// reports the best window after every letter.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid_i, in_stall_o, in_data_i | input
//   out     | out_valid_o, out_stall_i, out_data_o | output
//   cfg     | cfg_we_i, cfg_wdata_i (max_distinct) | input
//
// Steps: a letter already in the window passes check, update and finish; a new
//   letter check, loop, update and finish; an unknown letter code check and finish;
//   each eviction adds 26 scan steps on the single compare unit, evict and recheck.
// The input stalls from the transfer until the result is loaded; the next
//   transfer in can come in the cycle after.
// Reset clears all string state but the letter positions; max_distinct resets to 3.
// One item is in work at a time; the result register lets the next letter be
//   taken while a result still waits on out_stall_i.
// A letter whose result cannot be loaded waits in the finish state.
// ----------------------------------------------------------------------------
module longest_substring_k_distinct
  import lsk_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [KW-1:0]   cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lsk_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lsk_out_t        out_data_o
);

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StLoop,
    StScan,
    StEvict,
    StUpdate,
    StFinish
  } state_e;

  state_e                 state_q;
  logic [KW-1:0]          k_q;
  logic [LetterW-1:0]     letter_q;
  logic                   eos_q;
  logic [AlphabetSize-1:0] in_win_q;
  logic [PosW-1:0]        last_pos_q [AlphabetSize];
  logic [CntW-1:0]        count_q;
  logic [PosW-1:0]        wstart_q;
  logic [PosW-1:0]        pos_q;
  logic [LenW-1:0]        best_len_q;
  logic [PosW-1:0]        best_start_q;
  logic [PosW-1:0]        best_end_q;
  logic                   overflow_q;
  logic                   last_used_q;
  logic [IdxW-1:0]        idx_q;
  logic                   out_valid_q;
  lsk_out_t               out_q;

  lsk_scan_req_t          scan_req;
  lsk_scan_res_t          scan_res;

  logic [IdxW-1:0]        cidx;
  logic                   letter_ok;
  logic [CntW-1:0]        k_eff;
  logic                   need_evict;
  logic [LenW-1:0]        win_len;
  logic [LenW-1:0]        evict_start;
  logic [PosW-1:0]        new_start;
  logic                   out_free;

  // Letter decode and eviction condition
  assign cidx       = letter_q[IdxW-1:0];
  assign letter_ok  = (letter_q < LetterW'(AlphabetSize));
  assign k_eff      = (k_q == '0) ? CntW'(1) : CntW'(k_q);
  assign need_evict = (count_q >= k_eff) && (count_q != '0);
  assign win_len    = {1'b0, pos_q} - {1'b0, wstart_q} + LenW'(1);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Start after the evicted letter, held at the present position
  assign evict_start = {1'b0, scan_res.oldest} + LenW'(1);
  always_comb begin
    new_start = (evict_start > {1'b0, pos_q}) ? pos_q : evict_start[PosW-1:0];
  end

  // Scan unit feed
  always_comb begin
    scan_req.start       = (state_q == StLoop);
    scan_req.step        = (state_q == StScan);
    scan_req.idx         = idx_q;
    scan_req.entry_valid = in_win_q[idx_q];
    scan_req.entry_pos   = last_pos_q[idx_q];
  end

  lsk_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scan_req),
    .res_o  (scan_res)
  );

  // Sequencer and string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      k_q          <= KReset;
      letter_q     <= '0;
      eos_q        <= 1'b0;
      in_win_q     <= '0;
      count_q      <= '0;
      wstart_q     <= '0;
      pos_q        <= '0;
      best_len_q   <= '0;
      best_start_q <= '0;
      best_end_q   <= '0;
      overflow_q   <= 1'b0;
      last_used_q  <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
      // the finish state reloads the result register itself
      if (out_valid_q && !out_stall_i && (state_q != StFinish)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            letter_q <= in_data_i.letter;
            eos_q    <= in_data_i.end_of_string;
            state_q  <= StCheck;
          end
        end
        StCheck: begin
          if (!letter_ok) begin
            state_q <= StFinish;
          end else begin
            if (last_used_q) begin
              overflow_q <= 1'b1;
            end
            if (in_win_q[cidx]) begin
              state_q <= StUpdate;
            end else begin
              state_q <= StLoop;
            end
          end
        end
        StLoop: begin
          idx_q <= '0;
          if (need_evict) begin
            state_q <= StScan;
          end else begin
            state_q <= StUpdate;
          end
        end
        StScan: begin
          idx_q <= idx_q + IdxW'(1);
          if (idx_q == LastIdx) begin
            state_q <= StEvict;
          end
        end
        StEvict: begin
          if (!scan_res.found) begin
            count_q <= '0;
          end else begin
            in_win_q[scan_res.victim] <= 1'b0;
            count_q <= count_q - CntW'(1);
            if (new_start > wstart_q) begin
              wstart_q <= new_start;
            end
          end
          state_q <= StLoop;
        end
        StUpdate: begin
          if (!in_win_q[cidx]) begin
            in_win_q[cidx] <= 1'b1;
            count_q        <= count_q + CntW'(1);
          end
          if (win_len > best_len_q) begin
            best_len_q   <= win_len;
            best_start_q <= wstart_q;
            best_end_q   <= pos_q;
          end
          if (pos_q == LastPos) begin
            last_used_q <= 1'b1;
          end else begin
            pos_q <= pos_q + PosW'(1);
          end
          state_q <= StFinish;
        end
        StFinish: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
            if (eos_q) begin
              in_win_q     <= '0;
              count_q      <= '0;
              wstart_q     <= '0;
              pos_q        <= '0;
              best_len_q   <= '0;
              best_start_q <= '0;
              best_end_q   <= '0;
              overflow_q   <= 1'b0;
              last_used_q  <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Letter positions and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == StUpdate) begin
      last_pos_q[cidx] <= pos_q;
    end
    if (state_q == StFinish && out_free) begin
      out_q.best_length <= best_len_q;
      out_q.best_start  <= best_start_q;
      out_q.best_end    <= best_end_q;
      out_q.is_final    <= eos_q;
      out_q.too_long    <= overflow_q;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Occupancy count tracks the window bits between letters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> ($countones(in_win_q) == int'(count_q)))
    else $error("distinct count out of step with window bits");

  // Window never starts past the present position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wstart_q <= pos_q)
    else $error("window start passed current position");

  // Best window lies within the positions seen so far
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_len_q != '0) |-> ((best_start_q <= best_end_q) && (best_end_q <= pos_q)))
    else $error("best window inconsistent");

  // A transfer in starts work, so the block stalls the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while busy");

  // A scan always finds a victim when the window is not empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEvict) |-> scan_res.found)
    else $error("eviction scan found no letter");

endmodule
